// ===== rtl/sspq_pkg.sv =====
// ----------------------------------------------------------------------------
// sspq_pkg
// shared types and constants of the sorted seed priority queue: operation and
// status codes, item field widths and the controller/datapath link
// ----------------------------------------------------------------------------
package sspq_pkg;

    // item field widths
    localparam int OP_W       = 2;
    localparam int ID_IN_W    = 16;
    localparam int KEY_W      = 32;
    localparam int ST_W       = 2;
    localparam int OCC_W      = 7;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_FIELD_W = ID_IN_W + KEY_W + ST_W + OCC_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DECREASE = 2'd1,
        OP_POP      = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    // datapath actions, one per cycle
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,         // latch item, pointer to head, clear result
        DP_PTR_COUNT,    // pointer to the free slot behind the tail
        DP_RD_BELOW,     // read entry at pointer - 1
        DP_RD_PTR,       // read entry at pointer
        DP_RD_ABOVE,     // read entry at pointer + 1
        DP_INS_MOVE,     // write read entry at pointer, pointer down
        DP_INS_PLACE,    // write new entry at pointer, count up
        DP_PTR_INC,      // pointer up
        DP_SHIFT_MOVE,   // write read entry at pointer, pointer up
        DP_SHIFT_END,    // count down, pointer to the free slot behind the new tail
        DP_HEAD_CAPTURE, // keep read head entry as pop result
        DP_RESULT        // load output register
    } t_dp_act;

    typedef struct packed {
        t_dp_act act;
        t_status st;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    full;
        logic    empty;
        logic    ptr_zero;
        logic    ptr_at_count;
        logic    above_is_end;
        logic    key_ge;
        logic    id_hit;
        logic    out_free;
    } t_dp_stat;

endpackage

// ===== rtl/sorted_seed_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_seed_priority_queue_core
// ordered seed list for density-based cluster ordering: a sorted priority
// queue of (id, key) entries with insert, decrease-key and pop-minimum
// ----------------------------------------------------------------------------
// usage
//   slave channel: one operation per item, tuser carries the operation code
//   (insert, decrease, pop), tdata the object id and the unsigned q16.16 key
//   master channel: exactly one item per operation: popped id and key (zero
//   unless a pop succeeded), status and the occupancy after the operation
//   entries sit in a memory with one read port, sorted by ascending key;
//   equal keys keep the newest entry nearest the head
// operation steps
//   every memory step is a read, then a compare and write back
//   insert: from the tail, move each entry with an equal or larger key up
//   one slot, then place the new entry; decrease: find the id from the head,
//   shift the entries behind it down, then insert; pop: keep the head entry,
//   shift the rest down; s_axis_tready is high only in the idle state, so
//   the next item is taken in the cycle after the result is loaded at best
// reset
//   synchronous, active low: occupancy to zero, output register emptied and
//   s_axis_tready low; the memory is not cleared, only occupied slots are read
// stalls
//   a result waits in the output register while m_axis_tready is low; the
//   next item is still taken and worked, and it waits for the slot to free
// ----------------------------------------------------------------------------
module sorted_seed_priority_queue_core #(
    parameter int DEPTH    = 64,
    parameter int ID_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // operation items
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [15:0] object_id, [47:16] key
    input  logic [sspq_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] operation
    input  logic [sspq_pkg::OP_W-1:0]        i_s_axis_tuser,
    // result items
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [15:0] popped_id, [47:16] popped_key, [49:48] status,
    // [56:50] occupancy, [63:57] zero
    output logic [sspq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    sspq_pkg::t_dp_cmd  dp_cmd;
    sspq_pkg::t_dp_stat dp_stat;

    // sequencer: one action per cycle towards the datapath
    sspq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_stat  (dp_stat),
        .o_ready (o_s_axis_tready),
        .o_cmd   (dp_cmd)
    );

    // sorted entry memory, count, pointer and output register
    sspq_datapath #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_s_op    (i_s_axis_tuser),
        .i_s_data  (i_s_axis_tdata),
        .i_m_ready (i_m_axis_tready),
        .o_stat    (dp_stat),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_data  (o_m_axis_tdata)
    );

endmodule

// ===== rtl/sspq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sspq_ctrl
// sequencer of the seed queue: walks insert, search, shift and pop steps
// and issues one datapath action per cycle
// ----------------------------------------------------------------------------
module sspq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sspq_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output sspq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE        = 10'b00_0000_0001,
        S_DECODE      = 10'b00_0000_0010,
        S_INS_CHECK   = 10'b00_0000_0100,
        S_INS_EVAL    = 10'b00_0000_1000,
        S_FIND_CHECK  = 10'b00_0001_0000,
        S_FIND_EVAL   = 10'b00_0010_0000,
        S_POP_HEAD    = 10'b00_0100_0000,
        S_SHIFT_CHECK = 10'b00_1000_0000,
        S_SHIFT_EVAL  = 10'b01_0000_0000,
        S_DONE        = 10'b10_0000_0000
    } t_state;

    t_state            r_state, n_state;
    sspq_pkg::t_status r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= sspq_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    // no item is taken while reset is held
    assign o_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_st         = r_st;
        o_cmd.act    = sspq_pkg::DP_NONE;
        o_cmd.st     = r_st;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.act = sspq_pkg::DP_LOAD;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    sspq_pkg::OP_INSERT: begin
                        if (i_stat.full) begin
                            n_st    = sspq_pkg::ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.act = sspq_pkg::DP_PTR_COUNT;
                            n_state   = S_INS_CHECK;
                        end
                    end
                    sspq_pkg::OP_DECREASE: begin
                        n_state = S_FIND_CHECK;
                    end
                    sspq_pkg::OP_POP: begin
                        if (i_stat.empty) begin
                            n_st    = sspq_pkg::ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.act = sspq_pkg::DP_RD_PTR;
                            n_state   = S_POP_HEAD;
                        end
                    end
                    default: begin
                        n_st    = sspq_pkg::ST_OK;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INS_CHECK: begin
                if (i_stat.ptr_zero) begin
                    o_cmd.act = sspq_pkg::DP_INS_PLACE;
                    n_st      = sspq_pkg::ST_OK;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.act = sspq_pkg::DP_RD_BELOW;
                    n_state   = S_INS_EVAL;
                end
            end
            S_INS_EVAL: begin
                if (i_stat.key_ge) begin
                    o_cmd.act = sspq_pkg::DP_INS_MOVE;
                    n_state   = S_INS_CHECK;
                end else begin
                    o_cmd.act = sspq_pkg::DP_INS_PLACE;
                    n_st      = sspq_pkg::ST_OK;
                    n_state   = S_DONE;
                end
            end
            S_FIND_CHECK: begin
                if (i_stat.ptr_at_count) begin
                    n_st    = sspq_pkg::ST_ABSENT;
                    n_state = S_DONE;
                end else begin
                    o_cmd.act = sspq_pkg::DP_RD_PTR;
                    n_state   = S_FIND_EVAL;
                end
            end
            S_FIND_EVAL: begin
                if (i_stat.id_hit) begin
                    n_state = S_SHIFT_CHECK;
                end else begin
                    o_cmd.act = sspq_pkg::DP_PTR_INC;
                    n_state   = S_FIND_CHECK;
                end
            end
            S_POP_HEAD: begin
                o_cmd.act = sspq_pkg::DP_HEAD_CAPTURE;
                n_state   = S_SHIFT_CHECK;
            end
            S_SHIFT_CHECK: begin
                if (i_stat.above_is_end) begin
                    o_cmd.act = sspq_pkg::DP_SHIFT_END;
                    if (i_stat.op == sspq_pkg::OP_POP) begin
                        n_st    = sspq_pkg::ST_OK;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_INS_CHECK;
                    end
                end else begin
                    o_cmd.act = sspq_pkg::DP_RD_ABOVE;
                    n_state   = S_SHIFT_EVAL;
                end
            end
            S_SHIFT_EVAL: begin
                o_cmd.act = sspq_pkg::DP_SHIFT_MOVE;
                n_state   = S_SHIFT_CHECK;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.act = sspq_pkg::DP_RESULT;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sspq_datapath.sv =====
// ----------------------------------------------------------------------------
// sspq_datapath
// entry memory kept sorted by key, entry count, walking pointer, latched
// item and the output register
// ----------------------------------------------------------------------------
module sspq_datapath #(
    parameter int DEPTH    = 64,
    parameter int ID_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sspq_pkg::t_dp_cmd                   i_cmd,
    input  logic [sspq_pkg::OP_W-1:0]           i_s_op,
    input  logic [sspq_pkg::IN_TDATA_W-1:0]     i_s_data,
    input  logic                                i_m_ready,
    output sspq_pkg::t_dp_stat                  o_stat,
    output logic                                o_m_valid,
    output logic [sspq_pkg::OUT_TDATA_W-1:0]    o_m_data
);

    localparam int SID_W  = (ID_WIDTH < sspq_pkg::ID_IN_W) ? ID_WIDTH : sspq_pkg::ID_IN_W;
    localparam int ENT_W  = SID_W + sspq_pkg::KEY_W;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [ENT_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_ptr, n_ptr;
    sspq_pkg::t_opcode         r_op;
    logic [SID_W-1:0]          r_id;
    logic [sspq_pkg::KEY_W-1:0] r_key;
    logic [ENT_W-1:0]          r_rd;
    logic [SID_W-1:0]          r_res_id;
    logic [sspq_pkg::KEY_W-1:0] r_res_key;
    logic                      r_out_valid;
    logic [sspq_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                      rd_en, wr_en;
    logic [CNT_W-1:0]          rd_ptr;
    logic [ENT_W-1:0]          wr_data;
    logic [CNT_W-1:0]          ptr_up, ptr_dn;
    logic [SID_W-1:0]          rd_id;
    logic [sspq_pkg::KEY_W-1:0] rd_key;
    logic [sspq_pkg::OUT_FIELD_W-1:0] out_fields;
    logic                      out_free;

    assign ptr_up = CNT_W'(r_ptr + CNT_W'(1));
    assign ptr_dn = CNT_W'(r_ptr - CNT_W'(1));
    assign rd_id  = r_rd[SID_W-1:0];
    assign rd_key = r_rd[SID_W +: sspq_pkg::KEY_W];
    assign out_free = !r_out_valid || i_m_ready;

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_ptr  = r_ptr;
        wr_en   = 1'b0;
        wr_data = r_rd;
        n_count = r_count;
        n_ptr   = r_ptr;
        case (i_cmd.act)
            sspq_pkg::DP_LOAD:       n_ptr = '0;
            sspq_pkg::DP_PTR_COUNT:  n_ptr = r_count;
            sspq_pkg::DP_RD_BELOW: begin
                rd_en  = 1'b1;
                rd_ptr = ptr_dn;
            end
            sspq_pkg::DP_RD_PTR:     rd_en = 1'b1;
            sspq_pkg::DP_RD_ABOVE: begin
                rd_en  = 1'b1;
                rd_ptr = ptr_up;
            end
            sspq_pkg::DP_INS_MOVE: begin
                wr_en = 1'b1;
                n_ptr = ptr_dn;
            end
            sspq_pkg::DP_INS_PLACE: begin
                wr_en   = 1'b1;
                wr_data = {r_key, r_id};
                n_count = CNT_W'(r_count + CNT_W'(1));
            end
            sspq_pkg::DP_PTR_INC:    n_ptr = ptr_up;
            sspq_pkg::DP_SHIFT_MOVE: begin
                wr_en = 1'b1;
                n_ptr = ptr_up;
            end
            sspq_pkg::DP_SHIFT_END: begin
                n_count = CNT_W'(r_count - CNT_W'(1));
                n_ptr   = CNT_W'(r_count - CNT_W'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_ptr[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_op    <= sspq_pkg::OP_NOP;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
            if (i_cmd.act == sspq_pkg::DP_LOAD) begin
                r_op <= sspq_pkg::t_opcode'(i_s_op);
            end
        end
    end

    // item and pop result, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.act == sspq_pkg::DP_LOAD) begin
            r_id      <= SID_W'(i_s_data[sspq_pkg::ID_IN_W-1:0]);
            r_key     <= i_s_data[sspq_pkg::ID_IN_W +: sspq_pkg::KEY_W];
            r_res_id  <= '0;
            r_res_key <= '0;
        end else if (i_cmd.act == sspq_pkg::DP_HEAD_CAPTURE) begin
            r_res_id  <= rd_id;
            r_res_key <= rd_key;
        end
    end

    assign out_fields = {sspq_pkg::OCC_W'(r_count), i_cmd.st, r_res_key,
                         sspq_pkg::ID_IN_W'(r_res_id)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.act == sspq_pkg::DP_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == sspq_pkg::DP_RESULT) begin
            r_out_data <= sspq_pkg::OUT_TDATA_W'(out_fields);
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

    always_comb begin
        o_stat.op           = r_op;
        o_stat.full         = (r_count == CNT_W'(DEPTH));
        o_stat.empty        = (r_count == '0);
        o_stat.ptr_zero     = (r_ptr == '0);
        o_stat.ptr_at_count = (r_ptr == r_count);
        o_stat.above_is_end = (ptr_up == r_count);
        o_stat.key_ge       = (rd_key >= r_key);
        o_stat.id_hit       = (rd_id == r_id);
        o_stat.out_free     = out_free;
    end

endmodule

// ===== rtl/sspq_checker.sv =====
// ----------------------------------------------------------------------------
// sspq_checker
// port-level checks of the seed queue: reset, one item at a time, held
// results and result field consistency
// ----------------------------------------------------------------------------
module sspq_checker #(
    parameter int DEPTH = 64
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [sspq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic [sspq_pkg::ID_IN_W-1:0] res_id;
    logic [sspq_pkg::KEY_W-1:0]   res_key;
    logic [sspq_pkg::ST_W-1:0]    res_st;
    logic [sspq_pkg::OCC_W-1:0]   res_occ;

    assign res_id  = o_m_axis_tdata[15:0];
    assign res_key = o_m_axis_tdata[47:16];
    assign res_st  = o_m_axis_tdata[49:48];
    assign res_occ = o_m_axis_tdata[56:50];

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // a failed operation reports zero id and key
    a_no_pop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (res_st != sspq_pkg::ST_OK) |->
            (res_id == '0) && (res_key == '0))
        else $error("entry fields set on failed operation");

    // an accepted item closes the slave channel while it is worked
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("item taken while another is worked");

    // insert on full reports a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (res_st == sspq_pkg::ST_FULL) |->
            (res_occ == sspq_pkg::OCC_W'(DEPTH)))
        else $error("insert on full with wrong occupancy");

endmodule

bind sorted_seed_priority_queue_core sspq_checker #(
    .DEPTH (DEPTH)
) u_sspq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== test/tb_sorted_seed_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_seed_priority_queue_core
// self-checking bench for the sorted seed priority queue: a scoreboard keeps
// its own sorted list of (id, key) entries, predicts one result item per
// accepted operation item and compares every returned item field by field.
// directed items cover the corner cases, then fill-biased and drain-biased
// random phases push the queue between empty and full, with random idling
// on both stream channels.
// ----------------------------------------------------------------------------
module tb_sorted_seed_priority_queue_core;

    localparam int QDEPTH       = 64;
    localparam int QID_W        = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_WAIT   = 300;
    localparam int CYCLE_LIMIT  = 2000000;

    // expected content of one result item
    typedef struct {
        logic [sspq_pkg::ID_IN_W-1:0] id;
        logic [sspq_pkg::KEY_W-1:0]   key;
        sspq_pkg::t_status            st;
        logic [sspq_pkg::OCC_W-1:0]   occ;
    } t_result;

    // ------------------------------------------------------------------------
    // scoreboard: sorted seed list predictor and store of expected results
    // ------------------------------------------------------------------------
    class seed_list_scoreboard;
        logic [sspq_pkg::ID_IN_W-1:0] list_ids[$];
        logic [sspq_pkg::KEY_W-1:0]   list_keys[$];
        t_result                      awaited[$];
        int                           errors;
        int                           n_ops;
        int                           n_status[4];
        int                           peak_occ;

        function new();
            errors   = 0;
            n_ops    = 0;
            peak_occ = 0;
            foreach (n_status[i]) n_status[i] = 0;
        endfunction

        // new entry goes ahead of every entry with an equal or larger key
        function void place(logic [sspq_pkg::ID_IN_W-1:0] id,
                            logic [sspq_pkg::KEY_W-1:0] key);
            int pos;
            pos = 0;
            while (pos < list_keys.size() && list_keys[pos] < key) pos++;
            list_ids.insert(pos, id);
            list_keys.insert(pos, key);
        endfunction

        function void note_operation(sspq_pkg::t_opcode op,
                                     logic [sspq_pkg::ID_IN_W-1:0] id,
                                     logic [sspq_pkg::KEY_W-1:0] key);
            t_result r;
            int      pos;
            r.id  = '0;
            r.key = '0;
            r.st  = sspq_pkg::ST_OK;
            case (op)
                sspq_pkg::OP_INSERT: begin
                    if (list_ids.size() >= QDEPTH) r.st = sspq_pkg::ST_FULL;
                    else place(id, key);
                end
                sspq_pkg::OP_DECREASE: begin
                    // the matching entry nearest the head is moved
                    pos = 0;
                    while (pos < list_ids.size() && list_ids[pos] != id) pos++;
                    if (pos >= list_ids.size()) begin
                        r.st = sspq_pkg::ST_ABSENT;
                    end else begin
                        list_ids.delete(pos);
                        list_keys.delete(pos);
                        place(id, key);
                    end
                end
                sspq_pkg::OP_POP: begin
                    if (list_ids.size() == 0) begin
                        r.st = sspq_pkg::ST_EMPTY;
                    end else begin
                        r.id  = list_ids.pop_front();
                        r.key = list_keys.pop_front();
                    end
                end
                default: ;
            endcase
            r.occ = sspq_pkg::OCC_W'(list_ids.size());
            if (list_ids.size() > peak_occ) peak_occ = list_ids.size();
            n_status[r.st]++;
            n_ops++;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [sspq_pkg::KEY_W-1:0] exp_v,
                                    logic [sspq_pkg::KEY_W-1:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [sspq_pkg::OUT_TDATA_W-1:0] data);
            t_result r;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result item with nothing awaited, expected none, actual %h",
                         $time, data);
                return;
            end
            r = awaited.pop_front();
            compare_field("popped_id",  sspq_pkg::KEY_W'(r.id),
                          sspq_pkg::KEY_W'(data[15:0]));
            compare_field("popped_key", r.key, data[47:16]);
            compare_field("status",     sspq_pkg::KEY_W'(r.st),
                          sspq_pkg::KEY_W'(data[49:48]));
            compare_field("occupancy",  sspq_pkg::KEY_W'(r.occ),
                          sspq_pkg::KEY_W'(data[56:50]));
            compare_field("padding",    '0, sspq_pkg::KEY_W'(data[63:57]));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function int occupancy();
            return list_ids.size();
        endfunction

        // some id currently held, for decreases and duplicate inserts
        function logic [sspq_pkg::ID_IN_W-1:0] held_id();
            return list_ids[$urandom_range(0, list_ids.size() - 1)];
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block and stream signals
    // ------------------------------------------------------------------------
    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [sspq_pkg::IN_TDATA_W-1:0]  s_tdata;   // [15:0] object_id, [47:16] key
    logic [sspq_pkg::OP_W-1:0]        s_tuser;   // [1:0] operation
    logic                             m_tvalid;
    logic                             m_tready;
    // [15:0] id, [47:16] key, [49:48] status, [56:50] occupancy, [63:57] zero
    logic [sspq_pkg::OUT_TDATA_W-1:0] m_tdata;

    seed_list_scoreboard sb;
    int                  cycle_count;
    bit                  send_burst;   // sender phase without idling
    bit                  recv_burst;   // receiver stretch without stalls

    sorted_seed_priority_queue_core #(
        .DEPTH    (QDEPTH),
        .ID_WIDTH (QID_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    // one operation item; valid stays high into the next item when no gap
    task automatic send_operation(sspq_pkg::t_opcode op,
                                  logic [sspq_pkg::ID_IN_W-1:0] id,
                                  logic [sspq_pkg::KEY_W-1:0] key);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {key, id};
        do @(posedge i_clk); while (!s_tready);
        sb.note_operation(op, id, key);
    endtask

    // random phase, biased to fill or to drain the queue
    task automatic random_phase(int len, bit fill_bias);
        int                           r;
        int                           ins_lim;
        int                           dec_lim;
        sspq_pkg::t_opcode            op;
        logic [sspq_pkg::ID_IN_W-1:0] id;
        logic [sspq_pkg::KEY_W-1:0]   key;
        ins_lim = fill_bias ? 65 : 15;
        dec_lim = fill_bias ? 80 : 30;
        for (int n = 0; n < len; n++) begin
            r = $urandom_range(0, 99);
            if (r < ins_lim)      op = sspq_pkg::OP_INSERT;
            else if (r < dec_lim) op = sspq_pkg::OP_DECREASE;
            else if (r < 95)      op = sspq_pkg::OP_POP;
            else                  op = sspq_pkg::OP_NOP;
            // small key set gives plenty of ties, full range toggles every bit
            key = ($urandom_range(0, 9) < 4) ? {13'd0, 3'($urandom_range(0, 7)), 16'd0}
                                             : sspq_pkg::KEY_W'($urandom);
            r = $urandom_range(0, 99);
            if (sb.occupancy() > 0 && (op == sspq_pkg::OP_DECREASE ? r < 80 : r < 25))
                id = sb.held_id();
            else if (r < 60)
                id = sspq_pkg::ID_IN_W'($urandom_range(0, 15));
            else
                id = sspq_pkg::ID_IN_W'($urandom);
            send_operation(op, id, key);
        end
    endtask

    // result side: random stalls, check every accepted item
    initial begin
        int gap;
        m_tready <= 1'b0;
        recv_burst = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
            gap = draw_gap(recv_burst);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        int done;
        int len;
        bit fill;
        sb          = new();
        cycle_count = 0;
        send_burst  = 1'b0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= sspq_pkg::OP_NOP;
        s_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases
        send_operation(sspq_pkg::OP_POP,      16'h0000, 32'h0000_0000);  // pop on empty
        send_operation(sspq_pkg::OP_DECREASE, 16'h0005, 32'h0000_0001);  // absent id
        send_operation(sspq_pkg::OP_NOP,      16'hffff, 32'hffff_ffff);  // unused code
        send_operation(sspq_pkg::OP_INSERT,   16'h0000, 32'h0000_0000);
        send_operation(sspq_pkg::OP_INSERT,   16'hffff, 32'hffff_ffff);
        send_operation(sspq_pkg::OP_INSERT,   16'h1234, 32'h0001_0000);
        send_operation(sspq_pkg::OP_INSERT,   16'h0042, 32'h0001_0000);  // tie, newest first
        send_operation(sspq_pkg::OP_INSERT,   16'h0042, 32'h0000_8000);  // duplicate id
        send_operation(sspq_pkg::OP_DECREASE, 16'h0042, 32'hffff_ffff);  // to larger key
        send_operation(sspq_pkg::OP_DECREASE, 16'hffff, 32'h0000_0000);  // tie at the head
        send_operation(sspq_pkg::OP_DECREASE, 16'haaaa, 32'h0000_0000);  // absent id
        send_operation(sspq_pkg::OP_INSERT,   16'h5555, 32'haaaa_aaaa);
        send_operation(sspq_pkg::OP_INSERT,   16'haaaa, 32'h5555_5555);
        send_operation(sspq_pkg::OP_NOP,      16'h0000, 32'h0000_0000);
        repeat (8) send_operation(sspq_pkg::OP_POP, 16'h0000, 32'h0000_0000);

        // random phases swinging the queue between empty and full
        done = 0;
        fill = 1'b1;
        while (done < RANDOM_ITEMS) begin
            len = $urandom_range(100, 250);
            if (len > RANDOM_ITEMS - done) len = RANDOM_ITEMS - done;
            send_burst = ($urandom_range(0, 3) == 0);
            random_phase(len, fill);
            done += len;
            fill = !fill;
        end
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d operations: %0d ok, %0d pop on empty,",
                 sb.n_ops, sb.n_status[sspq_pkg::ST_OK], sb.n_status[sspq_pkg::ST_EMPTY]);
        $display("%0d insert on full, %0d absent decrease, peak occupancy %0d of %0d",
                 sb.n_status[sspq_pkg::ST_FULL], sb.n_status[sspq_pkg::ST_ABSENT],
                 sb.peak_occ, QDEPTH);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sspq_pkg.sv
rtl/sspq_ctrl.sv
rtl/sspq_datapath.sv
rtl/sorted_seed_priority_queue_core.sv
rtl/sspq_checker.sv
test/tb_sorted_seed_priority_queue_core.sv
